FILE: sv/arpc_pkg.sv
package arpc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] FUNC_FRAME  = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_ADD    = 2'd3;

  localparam logic [10:0] MIN_FRAME_BYTES = 11'd28;
  localparam logic [15:0] HTYPE_ETHERNET  = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  HLEN_MAC        = 8'h06;
  localparam logic [7:0]  PLEN_IPV4       = 8'h04;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY    = 16'h0002;
  localparam logic [7:0]  AGE_FRESH       = 8'd255;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] frame_bytes;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
  } in_t;

  typedef struct packed {
    logic        packet_taken;
    logic        send_reply;
    logic [31:0] reply_ip;
    logic [47:0] reply_mac;
    logic        lookup_hit;
    logic [47:0] found_mac;
    logic        send_request;
    logic [31:0] request_ip;
  } out_t;

  // Command from the sequencer to the entry store.
  typedef struct packed {
    logic             wr_en;
    logic             fresh_en;
    logic             tick_en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } store_cmd_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  age;
  } store_rd_t;

endpackage

FILE: sv/arpc_store.sv
module arpc_store
  import arpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_cmd_t cmd,
  output store_rd_t  rd
);

  logic [31:0] ip_mem  [CACHE_ENTRIES];
  logic [47:0] mac_mem [CACHE_ENTRIES];
  logic [7:0]  age_r   [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ip_mem[cmd.idx]  <= cmd.ip;
      mac_mem[cmd.idx] <= cmd.mac;
    end
    rd.ip  <= ip_mem[cmd.idx];
    rd.mac <= mac_mem[cmd.idx];
    rd.age <= age_r[cmd.idx];
  end

  // An age of zero marks an empty entry, so only the ages need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.wr_en || cmd.fresh_en) begin
      age_r[cmd.idx] <= AGE_FRESH;
    end else if (cmd.tick_en && age_r[cmd.idx] != '0) begin
      age_r[cmd.idx] <= age_r[cmd.idx] - 8'd1;
    end
  end

endmodule

FILE: sv/arp_cache_with_aging_unit.sv
// ARP cache of CACHE_ENTRIES aged entries. One item is handled at a time. A received
// frame that is dropped or carries an unknown opcode goes straight to the output state
// without a scan. Every other item walks all entries, one entry per cycle: a tick ages
// each entry, while lookups and learns pass each one through the single compare unit.
// Every scan ends in a resolve state, and a lookup hit then also passes through a fetch
// state to read the MAC. in_ready is high only while the unit is idle; a finished result
// waits in the output register without blocking the next transfer. The user must write
// own_ip through cfg_we/cfg_wdata only while the unit is idle; the unit does not enforce it.
module arp_cache_with_aging_unit
  import arpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_FETCH   = 3'd3;
  localparam logic [2:0] S_OUT     = 3'd4;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_LEARN  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CACHE_ENTRIES);

  logic [31:0]      own_ip_r;
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [7:0]       vic_age_r, vic_age_nxt;
  logic [31:0]      key_ip_r, key_ip_nxt;
  logic [47:0]      key_mac_r, key_mac_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  store_cmd_t       cmd;
  store_rd_t        rd;

  logic             frame_ok;

  arpc_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rd    (rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign frame_ok = (in_data.frame_bytes >= MIN_FRAME_BYTES) &&
                    (in_data.htype == HTYPE_ETHERNET) &&
                    (in_data.ptype == PTYPE_IPV4) &&
                    (in_data.hlen == HLEN_MAC) &&
                    (in_data.plen == PLEN_IPV4) &&
                    (in_data.target_ip == own_ip_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    vic_idx_nxt   = vic_idx_r;
    vic_age_nxt   = vic_age_r;
    key_ip_nxt    = key_ip_r;
    key_mac_nxt   = key_mac_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    cmd           = '0;
    cmd.ip        = key_ip_r;
    cmd.mac       = key_mac_r;

    // The shared compare unit looks at the entry read in the previous cycle.
    if (cmp_v_r) begin
      if (rd.age != '0 && rd.ip == key_ip_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = cmp_idx_r;
      end
      // Scanning upward with <= hands ties to the highest index.
      if (cmp_idx_r == '0 || rd.age <= vic_age_r) begin
        vic_idx_nxt = cmp_idx_r;
        vic_age_nxt = rd.age;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = S_SCAN;
          case (in_data.func)
            FUNC_FRAME: begin
              key_ip_nxt  = in_data.sender_ip;
              key_mac_nxt = in_data.sender_mac;
              res_nxt.packet_taken = frame_ok;
              if (frame_ok && in_data.opcode == ARP_OP_REQUEST) begin
                res_nxt.send_reply = 1'b1;
                res_nxt.reply_ip   = in_data.sender_ip;
                res_nxt.reply_mac  = in_data.sender_mac;
                op_nxt = OP_LEARN;
              end else if (frame_ok && in_data.opcode == ARP_OP_REPLY) begin
                op_nxt = OP_LEARN;
              end else begin
                op_nxt    = OP_NONE;
                state_nxt = S_OUT;
              end
            end
            FUNC_LOOKUP: begin
              key_ip_nxt = in_data.entry_ip;
              op_nxt     = OP_LOOKUP;
            end
            FUNC_TICK: begin
              op_nxt = OP_TICK;
            end
            default: begin
              key_ip_nxt  = in_data.entry_ip;
              key_mac_nxt = in_data.entry_mac;
              op_nxt      = OP_LEARN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r != CNT_END) begin
          cmd.idx     = cnt_r[IDX_W-1:0];
          cmd.tick_en = (op_r == OP_TICK);
          cmp_v_nxt   = (op_r != OP_TICK);
          cmp_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt = S_OUT;
        case (op_r)
          OP_LOOKUP: begin
            if (hit_r) begin
              cmd.idx      = hit_idx_r;
              cmd.fresh_en = 1'b1;
              state_nxt    = S_FETCH;
            end else begin
              res_nxt.send_request = 1'b1;
              res_nxt.request_ip   = key_ip_r;
            end
          end
          OP_LEARN: begin
            cmd.idx   = hit_r ? hit_idx_r : vic_idx_r;
            cmd.wr_en = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_FETCH: begin
        res_nxt.lookup_hit = 1'b1;
        res_nxt.found_mac  = rd.mac;
        state_nxt          = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r    <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_ip_r <= cfg_wdata;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_age_r  <= vic_age_nxt;
    key_ip_r   <= key_ip_nxt;
    key_mac_r  <= key_mac_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
